@@ sv/pei_pkg.sv @@
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, register indexes and fixed-point helpers for the 2D
// Euler particle integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERSE_MASS  = 3'd0,
    REG_BODY_MASS     = 3'd1,
    REG_SPEED_LIMIT   = 3'd2,
    REG_FRICTION_KEEP = 3'd3,
    REG_CLAMP_TO_AREA = 3'd4,
    REG_STEADY_FX     = 3'd5,
    REG_STEADY_FY     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_SET_VEL = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PX, S_PY, S_AX, S_AY, S_VX, S_VY, S_MX, S_MY, S_LIM, S_CMP,
    S_SQRT, S_QX, S_DX, S_DXW, S_QY, S_DY, S_DYW, S_FX, S_FY, S_FW,
    S_CLAMP, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_DONE
  } state_t;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_mode_t;

  // request to the root/divide unit
  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_req_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(S32_MAX)) return S32_MAX;
    if (v < 64'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // (a*b) >> 24, truncated toward zero, saturated
  function automatic logic signed [31:0] q24(input logic signed [67:0] p);
    logic [67:0] mag;
    logic [43:0] q;
    mag = p[67] ? 68'(-p) : 68'(p);
    q   = mag[67:24];
    if (p[67]) begin
      if (q > 44'h80000000) return S32_MIN;
      return 32'(-q);
    end
    if (q > 44'h7FFFFFFF) return S32_MAX;
    return q[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [47:0] energy_sat(input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] e;
    e = (hi + {32'd0, lo[63:32]}) >> 9;
    if (e[63:48] != 16'd0) return 48'hFFFFFFFFFFFF;
    return e[47:0];
  endfunction

endpackage

@@ sv/pei_if.sv @@
// ----------------------------------------------------------------------------
// pei_if
// Valid/ready channels for step items, result items and config writes.
// ----------------------------------------------------------------------------
interface pei_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [15:0]        elapsed_ticks;
  logic signed [31:0] frame_force_x;
  logic signed [31:0] frame_force_y;
  logic signed [31:0] load_pos_x;
  logic signed [31:0] load_pos_y;
  logic signed [31:0] load_vel_x;
  logic signed [31:0] load_vel_y;
  modport source (output valid, operation, elapsed_ticks, frame_force_x, frame_force_y,
                  load_pos_x, load_pos_y, load_vel_x, load_vel_y, input ready);
  modport sink (input valid, operation, elapsed_ticks, frame_force_x, frame_force_y,
                load_pos_x, load_pos_y, load_vel_x, load_vel_y, output ready);
endinterface

interface pei_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic [47:0]        energy_x;
  logic [47:0]        energy_y;
  logic               speed_limited;
  modport source (output valid, position_x, position_y, velocity_x, velocity_y,
                  accel_x, accel_y, energy_x, energy_y, speed_limited, input ready);
  modport sink (input valid, position_x, position_y, velocity_x, velocity_y,
                accel_x, accel_y, energy_x, energy_y, speed_limited, output ready);
endinterface

interface pei_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/pei_rootdiv.sv @@
// ----------------------------------------------------------------------------
// pei_rootdiv
// Iterative 64-bit integer square root and 64/32 divide, one bit per cycle.
// ----------------------------------------------------------------------------
module pei_rootdiv (
  input  logic            clk,
  input  logic            rst,
  input  pei_pkg::rd_req_t req,
  input  logic [63:0]     arg,
  input  logic [31:0]     divisor,
  output logic            done,
  output logic [31:0]     result
);
  import pei_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  rd_mode_t    mode;
  logic [63:0] rv, rres, rbit, t;
  logic [31:0] rem, dl, dq, dvs;
  logic [32:0] r2;

  assign t  = rres + rbit;
  assign r2 = {rem, dl[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      rv   <= arg;
      rres <= '0;
      rbit <= 64'h4000000000000000;
      rem  <= arg[63:32];  // below divisor: quotient fits 32 bits
      dl   <= arg[31:0];
      dq   <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (rv >= t) begin
        rv   <= rv - t;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
      if (r2 >= {1'b0, dvs}) begin
        rem <= 32'(r2 - {1'b0, dvs});
        dq  <= {dq[30:0], 1'b1};
      end else begin
        rem <= r2[31:0];
        dq  <= {dq[30:0], 1'b0};
      end
      dl <= {dl[30:0], 1'b0};
    end
  end

  assign result = (mode == RD_DIV) ? dq : rres[31:0];

endmodule

@@ sv/particle_euler_integrator_2d.sv @@
// ----------------------------------------------------------------------------
// particle_euler_integrator_2d
// Explicit Euler integrator for one 2D body, with speed limit, friction,
// area clamp and per-axis kinetic energy, on one shared 34x34 multiplier.
// ----------------------------------------------------------------------------
// Sequence: load/set/no-op items run only the energy states before the result;
//   a step item runs the full sequence, plus root + 2 divides when the speed limit engages.
// Throughput: one item at a time; set by the multiplier sequence and the
//   one-bit-per-cycle root/divide unit.
// Reset: synchronous; state, config and handshakes return to reset values.
module particle_euler_integrator_2d #(
  parameter int AREA_WIDTH  = 1024,
  parameter int AREA_HEIGHT = 768
) (
  input logic       clk,
  input logic       rst,
  pei_in_if.sink    item_in,
  pei_out_if.source result_out,
  pei_cfg_if.sink   cfg
);
  import pei_pkg::*;

  // upper bounds in Q16.16
  localparam logic signed [31:0] TOP_X = 32'(AREA_WIDTH) << 16;
  localparam logic signed [31:0] TOP_Y = 32'(AREA_HEIGHT) << 16;

  // config
  logic [31:0]        inverse_mass, body_mass;
  logic [30:0]        speed_limit;
  logic [24:0]        friction_keep;
  logic               clamp_to_area;
  logic signed [31:0] steady_force_x, steady_force_y;

  // body state and step temporaries
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic signed [31:0] ax, ay, vx, vy;
  logic signed [31:0] ffx, ffy;
  logic [15:0]        dt;
  logic [63:0]        v2, sq, lo;
  logic [31:0]        speed;
  logic [47:0]        ex, ey;
  logic               limited;

  state_t state, state_next;

  // shared multiplier: operands picked per state, product registered
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [63:0]        prod_u;

  rd_req_t     rd_req;
  logic [63:0] rd_arg;
  logic        rd_done;
  logic [31:0] rd_result;

  logic        too_fast;
  logic        in_acc;

  assign prod_u   = prod[63:0];
  assign too_fast = v2 > prod_u;
  assign in_acc   = item_in.valid && item_in.ready;

  assign item_in.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  pei_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .req     (rd_req),
    .arg     (rd_arg),
    .divisor (speed),
    .done    (rd_done),
    .result  (rd_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (op_t'(item_in.operation) == OP_STEP) ? S_PX : S_E1;
        end
      end
      S_PX:    state_next = S_PY;
      S_PY:    state_next = S_AX;
      S_AX:    state_next = S_AY;
      S_AY:    state_next = S_VX;
      S_VX:    state_next = S_VY;
      S_VY:    state_next = S_MX;
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_LIM;
      S_LIM:   state_next = S_CMP;
      S_CMP:   state_next = too_fast ? S_SQRT : S_FX;
      S_SQRT:  state_next = rd_done ? S_QX : S_SQRT;
      S_QX:    state_next = S_DX;
      S_DX:    state_next = S_DXW;
      S_DXW:   state_next = rd_done ? S_QY : S_DXW;
      S_QY:    state_next = S_DY;
      S_DY:    state_next = S_DYW;
      S_DYW:   state_next = rd_done ? S_FX : S_DYW;
      S_FX:    state_next = S_FY;
      S_FY:    state_next = S_FW;
      S_FW:    state_next = S_CLAMP;
      S_CLAMP: state_next = S_E1;
      S_E1:    state_next = S_E2;
      S_E2:    state_next = S_E3;
      S_E3:    state_next = S_E4;
      S_E4:    state_next = S_E5;
      S_E5:    state_next = S_E6;
      S_E6:    state_next = S_E7;
      S_E7:    state_next = S_DONE;
      S_DONE:  state_next = (!result_out.valid || result_out.ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operands and root/divide requests
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    rd_req.start  = 1'b0;
    rd_req.mode   = RD_SQRT;
    rd_arg        = v2;
    case (state)
      S_PX: begin mul_a = 34'(vel_x); mul_b = {18'd0, dt}; end
      S_PY: begin mul_a = 34'(vel_y); mul_b = {18'd0, dt}; end
      S_AX: begin
        mul_a = 34'(ffx) + 34'(steady_force_x);
        mul_b = {2'd0, inverse_mass};
      end
      S_AY: begin
        mul_a = 34'(ffy) + 34'(steady_force_y);
        mul_b = {2'd0, inverse_mass};
      end
      S_VX: begin mul_a = 34'(ax); mul_b = {18'd0, dt}; end
      S_VY: begin mul_a = 34'(ay); mul_b = {18'd0, dt}; end
      S_MX: begin mul_a = {2'd0, abs32(vx)}; mul_b = {2'd0, abs32(vx)}; end
      S_MY: begin mul_a = {2'd0, abs32(vy)}; mul_b = {2'd0, abs32(vy)}; end
      S_LIM: begin mul_a = {3'd0, speed_limit}; mul_b = {3'd0, speed_limit}; end
      S_CMP: rd_req.start = too_fast;
      S_QX: begin mul_a = {2'd0, abs32(vx)}; mul_b = {3'd0, speed_limit}; end
      S_QY: begin mul_a = {2'd0, abs32(vy)}; mul_b = {3'd0, speed_limit}; end
      S_DX, S_DY: begin
        rd_req.start = 1'b1;
        rd_req.mode  = RD_DIV;
        rd_arg       = prod_u;
      end
      S_FX: begin mul_a = 34'(vx); mul_b = {9'd0, friction_keep}; end
      S_FY: begin mul_a = 34'(vy); mul_b = {9'd0, friction_keep}; end
      S_E1: begin mul_a = {2'd0, abs32(vel_x)}; mul_b = {2'd0, abs32(vel_x)}; end
      S_E2, S_E5: begin mul_a = {2'd0, body_mass}; mul_b = {2'd0, prod_u[31:0]}; end
      S_E3, S_E6: begin mul_a = {2'd0, body_mass}; mul_b = {2'd0, sq[63:32]}; end
      S_E4: begin mul_a = {2'd0, abs32(vel_y)}; mul_b = {2'd0, abs32(vel_y)}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mass   <= 32'h01000000;
      body_mass      <= 32'd256;
      speed_limit    <= 31'h7FFFFFFF;
      friction_keep  <= 25'h1000000;
      clamp_to_area  <= 1'b1;
      steady_force_x <= '0;
      steady_force_y <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        REG_INVERSE_MASS:  inverse_mass   <= cfg.data;
        REG_BODY_MASS:     body_mass      <= cfg.data;
        REG_SPEED_LIMIT:   speed_limit    <= cfg.data[30:0];
        REG_FRICTION_KEEP: friction_keep  <= cfg.data[24:0];
        REG_CLAMP_TO_AREA: clamp_to_area  <= cfg.data[0];
        REG_STEADY_FX:     steady_force_x <= cfg.data;
        REG_STEADY_FY:     steady_force_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // body state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      vel_x <= '0;
      vel_y <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (op_t'(item_in.operation))
              OP_LOAD: begin
                pos_x <= item_in.load_pos_x;
                pos_y <= item_in.load_pos_y;
                vel_x <= '0;
                vel_y <= '0;
              end
              OP_SET_VEL: begin
                vel_x <= item_in.load_vel_x;
                vel_y <= item_in.load_vel_y;
              end
              default: ;
            endcase
          end
        end
        // floor shift: arithmetic shift of the signed product
        S_PY: pos_x <= sat32(64'(pos_x) + 64'(prod >>> 8));
        S_AX: pos_y <= sat32(64'(pos_y) + 64'(prod >>> 8));
        S_FY: vel_x <= q24(prod);
        S_FW: vel_y <= q24(prod);
        S_CLAMP: begin
          if (clamp_to_area) begin
            if (pos_x < 0) begin
              pos_x <= '0; vel_x <= '0;
            end else if (pos_x > TOP_X) begin
              pos_x <= TOP_X; vel_x <= '0;
            end
            if (pos_y < 0) begin
              pos_y <= '0; vel_y <= '0;
            end else if (pos_y > TOP_Y) begin
              pos_y <= TOP_Y; vel_y <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // step temporaries
  always_ff @(posedge clk) begin
    if (rst) begin
      ax      <= '0;
      ay      <= '0;
      limited <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            dt      <= item_in.elapsed_ticks;
            ffx     <= item_in.frame_force_x;
            ffy     <= item_in.frame_force_y;
            ax      <= '0;
            ay      <= '0;
            limited <= 1'b0;
          end
        end
        S_AY:  ax <= q24(prod);
        S_VX:  ay <= q24(prod);
        S_VY:  vx <= sat32(64'(vel_x) + 64'(prod));
        S_MX:  vy <= sat32(64'(vel_y) + 64'(prod));
        S_MY:  v2 <= prod_u;
        S_LIM: v2 <= v2 + prod_u;
        S_CMP: limited <= too_fast;
        S_SQRT: if (rd_done) speed <= rd_result;
        S_DXW: if (rd_done) vx <= vx[31] ? 32'(-rd_result) : 32'(rd_result);
        S_DYW: if (rd_done) vy <= vy[31] ? 32'(-rd_result) : 32'(rd_result);
        S_CLAMP: begin
          if (clamp_to_area) begin
            if (pos_x < 0 || pos_x > TOP_X) ax <= '0;
            if (pos_y < 0 || pos_y > TOP_Y) ay <= '0;
          end
        end
        S_E2, S_E5: sq <= prod_u;
        S_E3, S_E6: lo <= prod_u;
        S_E4: ex <= energy_sat(prod_u, lo);
        S_E7: ey <= energy_sat(prod_u, lo);
        default: ;
      endcase
    end
  end

  // result register: holds the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (state == S_DONE && (!result_out.valid || result_out.ready)) begin
      result_out.valid <= 1'b1;
    end else if (result_out.valid && result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_out.valid || result_out.ready)) begin
      result_out.position_x    <= pos_x;
      result_out.position_y    <= pos_y;
      result_out.velocity_x    <= vel_x;
      result_out.velocity_y    <= vel_y;
      result_out.accel_x       <= ax;
      result_out.accel_y       <= ay;
      result_out.energy_x      <= ex;
      result_out.energy_y      <= ey;
      result_out.speed_limited <= limited;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !item_in.ready)
    else $error("input taken while an item is in work");

  a_rd_done_expected: assert property (@(posedge clk) disable iff (rst)
    rd_done |-> (state == S_SQRT || state == S_DXW || state == S_DYW))
    else $error("root/divide finished outside a wait state");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!result_out.valid && state == S_IDLE))
    else $error("reset did not clear control state");

  a_limit_only_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> limited)
    else $error("root started without the limit flag");

endmodule

@@ tb/particle_euler_integrator_2d_test.sv @@
// ----------------------------------------------------------------------------
// particle_euler_integrator_2d_test
// Drives step, load, set-velocity and no-op items into the 2D Euler
// integrator, predicts each result from a local model and compares fields.
// ----------------------------------------------------------------------------
module particle_euler_integrator_2d_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pei_pkg::*;

  localparam int AREA_W = 1024;
  localparam int AREA_H = 768;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [47:0]        ex;
    logic [47:0]        ey;
    logic               limited;
  } motion_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        ticks;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] lpx;
    logic signed [31:0] lpy;
    logic signed [31:0] lvx;
    logic signed [31:0] lvy;
  } cmd_t;

  // directed row: command plus an optional typed-in expectation
  typedef struct {
    cmd_t    cmd;
    bit      fixed;
    motion_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pei_in_if  item_ch ();
  pei_out_if res_ch ();
  pei_cfg_if cfg_ch ();

  particle_euler_integrator_2d i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: body state and register copies
  // ---------------------------------------------------------------------------
  logic [31:0]        m_inv_mass;
  logic [31:0]        m_body_mass;
  logic [30:0]        m_speed_lim;
  logic [24:0]        m_friction;
  logic               m_clamp;
  logic signed [31:0] m_steady_fx;
  logic signed [31:0] m_steady_fy;
  logic signed [31:0] b_px, b_py, b_vx, b_vy;

  motion_t expected_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      sink_drain = 1'b0;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // (a*b)>>24 truncated toward zero, saturated
  function automatic logic signed [31:0] scale_q24(longint a, logic [31:0] b);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    q = (mag * 64'(b)) >> 24;
    if (a < 0) begin
      if (q > 64'h80000000) return 32'sh80000000;
      return 32'(-longint'(q));
    end
    if (q > 64'h7FFFFFFF) return 32'sh7FFFFFFF;
    return q[31:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] kinetic(logic signed [31:0] v);
    logic [63:0] m, sq, lo, hi, e;
    m = v[31] ? 64'(-longint'(v)) : 64'(v);
    sq = m * m;
    lo = 64'(m_body_mass) * {32'd0, sq[31:0]};
    hi = 64'(m_body_mass) * {32'd0, sq[63:32]};
    e = (hi + (lo >> 32)) >> 9;
    if (e > 64'hFFFFFFFFFFFF) e = 64'hFFFFFFFFFFFF;
    return e[47:0];
  endfunction

  // floor(v / 256) for signed v
  function automatic longint floor_div256(longint v);
    return v >>> 8;
  endfunction

  task automatic clamp_axis(inout logic signed [31:0] p, inout logic signed [31:0] v,
                            inout logic signed [31:0] a, input int lim);
    logic signed [31:0] top;
    top = 32'(lim) << 16;
    if (p < 0) begin
      p = 0; v = 0; a = 0;
    end else if (p > top) begin
      p = top; v = 0; a = 0;
    end
  endtask

  task automatic advance_body(input cmd_t c, output motion_t r);
    logic signed [31:0] ax, ay;
    longint dt, vx, vy;
    logic [63:0] mx, my, v2, lim, spd, qx, qy;
    ax = 0; ay = 0;
    r.limited = 1'b0;
    case (c.op)
      OP_STEP: begin
        dt = longint'(c.ticks);
        b_px = clip32(longint'(b_px) + floor_div256(longint'(b_vx) * dt));
        b_py = clip32(longint'(b_py) + floor_div256(longint'(b_vy) * dt));
        ax = scale_q24(longint'(c.fx) + longint'(m_steady_fx), m_inv_mass);
        ay = scale_q24(longint'(c.fy) + longint'(m_steady_fy), m_inv_mass);
        vx = longint'(clip32(longint'(b_vx) + longint'(ax) * dt));
        vy = longint'(clip32(longint'(b_vy) + longint'(ay) * dt));
        mx = 64'(vx < 0 ? -vx : vx);
        my = 64'(vy < 0 ? -vy : vy);
        v2 = mx * mx + my * my;
        lim = 64'(m_speed_lim);
        if (v2 > lim * lim) begin
          spd = root_floor(v2);
          qx = mx * lim / spd;
          qy = my * lim / spd;
          vx = vx < 0 ? -longint'(qx) : longint'(qx);
          vy = vy < 0 ? -longint'(qy) : longint'(qy);
          r.limited = 1'b1;
        end
        b_vx = scale_q24(vx, 32'(m_friction));
        b_vy = scale_q24(vy, 32'(m_friction));
        if (m_clamp) begin
          clamp_axis(b_px, b_vx, ax, AREA_W);
          clamp_axis(b_py, b_vy, ay, AREA_H);
        end
      end
      OP_LOAD: begin
        b_px = c.lpx; b_py = c.lpy; b_vx = 0; b_vy = 0;
      end
      OP_SET_VEL: begin
        b_vx = c.lvx; b_vy = c.lvy;
      end
      default: ;
    endcase
    r.px = b_px; r.py = b_py; r.vx = b_vx; r.vy = b_vy;
    r.ax = ax; r.ay = ay;
    r.ex = kinetic(b_vx);
    r.ey = kinetic(b_vy);
  endtask

  task automatic model_reset();
    m_inv_mass = 32'd16777216;
    m_body_mass = 32'd256;
    m_speed_lim = 31'h7FFFFFFF;
    m_friction = 25'd16777216;
    m_clamp = 1'b1;
    m_steady_fx = 0;
    m_steady_fy = 0;
    b_px = 0; b_py = 0; b_vx = 0; b_vy = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Driving helpers (inputs change on the falling edge)
  // ---------------------------------------------------------------------------
  task automatic gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 45) n = 0;
    else if (n < 92) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 60);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_INVERSE_MASS:  m_inv_mass = val;
      REG_BODY_MASS:     m_body_mass = val;
      REG_SPEED_LIMIT:   m_speed_lim = val[30:0];
      REG_FRICTION_KEEP: m_friction = val[24:0];
      REG_CLAMP_TO_AREA: m_clamp = val[0];
      REG_STEADY_FX:     m_steady_fx = val;
      REG_STEADY_FY:     m_steady_fy = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // send one item; predict at the accepting edge
  task automatic send_item(cmd_t c, bit fixed, motion_t want);
    motion_t r;
    item_ch.valid = 1'b1;
    item_ch.operation = c.op;
    item_ch.elapsed_ticks = c.ticks;
    item_ch.frame_force_x = c.fx;
    item_ch.frame_force_y = c.fy;
    item_ch.load_pos_x = c.lpx;
    item_ch.load_pos_y = c.lpy;
    item_ch.load_vel_x = c.lvx;
    item_ch.load_vel_y = c.lvy;
    do @(posedge clk); while (!item_ch.ready);
    advance_body(c, r);
    expected_q.push_back(fixed ? want : r);
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_wide();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t rnd_cmd(bit tame);
    cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.op = k < 70 ? OP_STEP : k < 82 ? OP_LOAD : k < 95 ? OP_SET_VEL : OP_NOP;
    c.ticks = tame ? 16'($urandom_range(0, 40)) : 16'($urandom());
    // mostly in-area positions and moderate motion, occasionally full range
    c.fx = tame ? 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rnd_wide();
    c.fy = tame ? 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)) : rnd_wide();
    c.lpx = tame ? 32'($urandom_range(0, AREA_W << 16)) : rnd_wide();
    c.lpy = tame ? 32'($urandom_range(0, AREA_H << 16)) : rnd_wide();
    c.lvx = tame ? 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27)) : rnd_wide();
    c.lvy = tame ? 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27)) : rnd_wide();
    return c;
  endfunction

  function automatic cmd_t mk(op_t op, logic [15:0] t, logic [31:0] fx, logic [31:0] fy,
                              logic [31:0] lx, logic [31:0] ly);
    cmd_t c;
    c = '{op, t, fx, fy, lx, ly, lx, ly};
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking at the rising edge
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    motion_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result item", $realtime);
      end else begin
        w = expected_q.pop_front();
        compare_field("position_x", 48'(w.px), 48'(res_ch.position_x));
        compare_field("position_y", 48'(w.py), 48'(res_ch.position_y));
        compare_field("velocity_x", 48'(w.vx), 48'(res_ch.velocity_x));
        compare_field("velocity_y", 48'(w.vy), 48'(res_ch.velocity_y));
        compare_field("accel_x", 48'(w.ax), 48'(res_ch.accel_x));
        compare_field("accel_y", 48'(w.ay), 48'(res_ch.accel_y));
        compare_field("energy_x", w.ex, res_ch.energy_x);
        compare_field("energy_y", w.ey, res_ch.energy_y);
        compare_field("speed_limited", 48'(w.limited), 48'(res_ch.speed_limited));
      end
    end
  end

  // watchdog: cycles without any handshake on the item, result or config channel
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stalls at random, with quiet stretches
  initial begin
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_drain || $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        res_ch.ready <= 1'b0;
        if (n < 90) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(10, 80)) @(negedge clk);
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t rows[$];
    row_t rw;
    motion_t zero;
    motion_t z;
    cmd_t c;
    int phase;

    item_ch.valid = 1'b0;
    item_ch.operation = OP_NOP;
    item_ch.elapsed_ticks = '0;
    item_ch.frame_force_x = '0;
    item_ch.frame_force_y = '0;
    item_ch.load_pos_x = '0;
    item_ch.load_pos_y = '0;
    item_ch.load_vel_x = '0;
    item_ch.load_vel_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INVERSE_MASS;
    cfg_ch.data = '0;
    zero = '0;
    model_reset();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; typed expectations after reset and for plain loads
    rw.fixed = 1'b1; rw.want = zero;
    rw.cmd = mk(OP_NOP, 16'd0, 0, 0, 0, 0); rows.push_back(rw);
    rw.cmd = mk(OP_STEP, 16'd0, 0, 0, 0, 0); rows.push_back(rw);
    z = zero; z.px = 32'sh00100000; z.py = 32'sh00200000;
    rw.want = z;
    rw.cmd = mk(OP_LOAD, 16'd7, 32'h7FFFFFFF, 32'h80000000, 32'h00100000, 32'h00200000);
    rows.push_back(rw);
    // load position outside area stays unclamped
    z = zero; z.px = 32'sh80000000; z.py = 32'sh7FFFFFFF; rw.want = z;
    rw.cmd = mk(OP_LOAD, 16'hFFFF, 0, 0, 32'h80000000, 32'h7FFFFFFF); rows.push_back(rw);
    rw.fixed = 1'b0;
    rw.cmd = mk(OP_STEP, 16'd1, 0, 0, 0, 0); rows.push_back(rw);   // clamps both axes
    rw.cmd = mk(OP_LOAD, 16'd0, 0, 0, 32'h01000000, 32'h01000000); rows.push_back(rw);
    rw.cmd = mk(OP_SET_VEL, 16'd0, 0, 0, 32'h7FFFFFFF, 32'h80000000); rows.push_back(rw);
    rw.cmd = mk(OP_NOP, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    rows.push_back(rw);
    rw.cmd = mk(OP_STEP, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0); rows.push_back(rw);
    rw.cmd = mk(OP_SET_VEL, 16'd0, 0, 0, 32'h00030000, 32'hFFFC0000); rows.push_back(rw);
    rw.cmd = mk(OP_STEP, 16'd16, 32'h01000000, 32'hFF000000, 0, 0); rows.push_back(rw);
    rw.cmd = mk(OP_STEP, 16'd1, 32'h80000000, 32'h7FFFFFFF, 0, 0); rows.push_back(rw);
    foreach (rows[i]) begin
      gap();
      send_item(rows[i].cmd, rows[i].fixed, rows[i].want);
    end
    drain();

    // speed limit: 3-4-5 case exactly at the limit, then just above it
    write_reg(REG_SPEED_LIMIT, 32'h00050000);
    write_reg(REG_CLAMP_TO_AREA, 32'd0);
    send_item(mk(OP_SET_VEL, 0, 0, 0, 32'h00030000, 32'h00040000), 1'b0, zero);
    send_item(mk(OP_STEP, 16'd2, 0, 0, 0, 0), 1'b0, zero);
    send_item(mk(OP_SET_VEL, 0, 0, 0, 32'h00030001, 32'hFFFC0000), 1'b0, zero);
    send_item(mk(OP_STEP, 16'd2, 0, 0, 0, 0), 1'b0, zero);
    drain();
    write_reg(REG_SPEED_LIMIT, 32'd0);
    send_item(mk(OP_STEP, 16'd1, 32'h00010000, 0, 0, 0), 1'b0, zero);
    drain();

    // random phases, each with a new register setting incl. extremes
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_INVERSE_MASS, 32'hFFFFFFFF); write_reg(REG_BODY_MASS, 32'hFFFFFFFF);
          write_reg(REG_SPEED_LIMIT, 32'h7FFFFFFF); write_reg(REG_FRICTION_KEEP, 32'd0);
          write_reg(REG_CLAMP_TO_AREA, 32'd1);
          write_reg(REG_STEADY_FX, 32'h7FFFFFFF); write_reg(REG_STEADY_FY, 32'h80000000);
        end
        1: begin
          write_reg(REG_INVERSE_MASS, 32'd0); write_reg(REG_BODY_MASS, 32'd0);
          write_reg(REG_FRICTION_KEEP, 32'h01000000);
          write_reg(REG_STEADY_FX, 32'h80000000); write_reg(REG_STEADY_FY, 32'h7FFFFFFF);
        end
        2: begin
          write_reg(REG_INVERSE_MASS, 32'h01000000); write_reg(REG_BODY_MASS, 32'd256);
          write_reg(REG_STEADY_FX, 32'd0); write_reg(REG_STEADY_FY, 32'hFFF00000);
          write_reg(REG_SPEED_LIMIT, 32'h02000000);
        end
        default: begin
          write_reg(REG_INVERSE_MASS, $urandom_range(0, 1) ? $urandom() : 32'h01000000);
          write_reg(REG_BODY_MASS, $urandom());
          write_reg(REG_SPEED_LIMIT, $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 27))
                                                          : ($urandom() >> 1));
          write_reg(REG_FRICTION_KEEP, $urandom_range(0, 1 << 24));
          write_reg(REG_CLAMP_TO_AREA, $urandom_range(0, 1));
          write_reg(REG_STEADY_FX, rnd_wide());
          write_reg(REG_STEADY_FY, rnd_wide());
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 10; n++) begin
        gap();
        c = rnd_cmd($urandom_range(0, 99) < 75);
        send_item(c, 1'b0, zero);
        // hold the sender until everything has come back
        if (n == 40) while (expected_q.size() != 0) @(negedge clk);
      end
      drain();
    end

    sink_drain = 1'b1;
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
